// ===== sv/trl_pkg.sv =====
// ----------------------------------------------------------------------------
// trl_pkg
// shared widths, register indexes and controller/datapath command types
// ----------------------------------------------------------------------------
`default_nettype none

package trl_pkg;

  localparam int THR_W      = 10;
  localparam int TIME_W     = 32;
  localparam int SPD_W      = 8;
  localparam int WAIT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // |throttle offset| * |speed span| <= 1023 * 255 < 2**18
  localparam int QUO_W      = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_NEUTRAL      = 3'd0,
    CFG_FULL_THROTTLE    = 3'd1,
    CFG_MIN_SPEED        = 3'd2,
    CFG_MAX_SPEED        = 3'd3,
    CFG_RAMP_STEP        = 3'd4,
    CFG_WAIT_MS          = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic finish;
  } trl_cmd_t;

  typedef struct packed {
    logic out_free;
  } trl_sts_t;

endpackage

`default_nettype wire

// ===== sv/trl_if.sv =====
// ----------------------------------------------------------------------------
// trl interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface trl_in_if;
  logic                       valid;
  logic                       ready;
  logic [trl_pkg::THR_W-1:0]  throttle;
  logic [trl_pkg::TIME_W-1:0] time_ms;
  modport source (output valid, output throttle, output time_ms, input ready);
  modport sink   (input valid, input throttle, input time_ms, output ready);
endinterface

interface trl_out_if;
  logic                      valid;
  logic                      ready;
  logic [trl_pkg::SPD_W-1:0] speed;
  logic [trl_pkg::SPD_W-1:0] target_speed;
  logic                      stepped;
  modport source (output valid, output speed, output target_speed, output stepped,
                  input ready);
  modport sink   (input valid, input speed, input target_speed, input stepped,
                  output ready);
endinterface

interface trl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trl_pkg::CFG_IDX_W-1:0]  index;
  logic [trl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/trl_ctrl.sv =====
// ----------------------------------------------------------------------------
// trl_ctrl
// sequences one request through product, serial divide and finish
// ----------------------------------------------------------------------------
`default_nettype none

module trl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trl_pkg::trl_sts_t sts,
  output trl_pkg::trl_cmd_t      cmd
);

  localparam int CNT_W = $clog2(trl_pkg::QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(trl_pkg::QUO_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cmd          = '0;
    in_ready     = (state == ST_IDLE);
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_FIN) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_MUL;
        end
        ST_MUL: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) state <= ST_FIN;
        end
        ST_FIN: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/trl_dp.sv =====
// ----------------------------------------------------------------------------
// trl_dp
// config registers, mapping product, restoring divider, ramp state, output reg
// ----------------------------------------------------------------------------
`default_nettype none

module trl_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire trl_pkg::trl_cmd_t              cmd,
  output trl_pkg::trl_sts_t                   sts,
  input  wire logic                           cfg_we,
  input  wire logic [trl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [trl_pkg::THR_W-1:0]      in_throttle,
  input  wire logic [trl_pkg::TIME_W-1:0]     in_time_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [trl_pkg::SPD_W-1:0]           out_speed,
  output logic [trl_pkg::SPD_W-1:0]           out_target_speed,
  output logic                                out_stepped
);

  localparam int THR_W  = trl_pkg::THR_W;
  localparam int SPD_W  = trl_pkg::SPD_W;
  localparam int QUO_W  = trl_pkg::QUO_W;
  localparam int TIME_W = trl_pkg::TIME_W;
  localparam int DIFF_W = THR_W + 1;
  localparam int SPAN_W = SPD_W + 1;
  localparam int PROD_W = DIFF_W + SPAN_W;
  localparam int VAL_W  = QUO_W + 3;

  // configuration
  logic [THR_W-1:0]           thr_neutral;
  logic [THR_W-1:0]           full_throttle;
  logic [SPD_W-1:0]           min_speed;
  logic [SPD_W-1:0]           max_speed;
  logic [SPD_W-1:0]           ramp_step;
  logic [trl_pkg::WAIT_W-1:0] wait_ms;

  // ramp state
  logic [SPD_W-1:0]  current_speed;
  logic [TIME_W-1:0] last_step_time;

  // working registers
  logic signed [DIFF_W-1:0] thr_off;
  logic signed [SPAN_W-1:0] spd_span;
  logic signed [DIFF_W-1:0] den;
  logic [TIME_W-1:0]        now;
  logic [QUO_W-1:0]         quo;
  logic [THR_W-1:0]         rem;
  logic [THR_W-1:0]         dmag;
  logic                     neg;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_abs;
  logic [DIFF_W-1:0]        den_abs;
  logic [THR_W:0]           shifted;
  logic                     sub_ok;

  logic signed [VAL_W-1:0]  qs;
  logic signed [VAL_W-1:0]  val;
  logic signed [VAL_W-1:0]  lo_s;
  logic signed [VAL_W-1:0]  hi_s;
  logic [SPD_W-1:0]         target;
  logic [TIME_W-1:0]        elapsed;
  logic                     step;
  logic [SPD_W:0]           up_sum;
  logic signed [SPD_W+1:0]  dn_diff;
  logic [SPD_W-1:0]         speed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_neutral      <= '0;
      full_throttle    <= '1;
      min_speed        <= '0;
      max_speed        <= '1;
      ramp_step        <= SPD_W'(1);
      wait_ms          <= trl_pkg::WAIT_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        trl_pkg::CFG_THR_NEUTRAL:      thr_neutral      <= cfg_data[THR_W-1:0];
        trl_pkg::CFG_FULL_THROTTLE:    full_throttle    <= cfg_data[THR_W-1:0];
        trl_pkg::CFG_MIN_SPEED:        min_speed        <= cfg_data[SPD_W-1:0];
        trl_pkg::CFG_MAX_SPEED:        max_speed        <= cfg_data[SPD_W-1:0];
        trl_pkg::CFG_RAMP_STEP:        ramp_step        <= cfg_data[SPD_W-1:0];
        trl_pkg::CFG_WAIT_MS:          wait_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

  // product and magnitudes
  always_comb begin
    prod     = PROD_W'(thr_off) * PROD_W'(spd_span);
    prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    den_abs  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
  end

  // one restoring divide bit
  always_comb begin
    shifted = {rem, quo[QUO_W-1]};
    sub_ok  = shifted >= {1'b0, dmag};
  end

  // target mapping, clamp and ramp step
  always_comb begin
    qs   = neg ? -VAL_W'({1'b0, quo}) : VAL_W'({1'b0, quo});
    lo_s = VAL_W'({1'b0, min_speed});
    hi_s = VAL_W'({1'b0, max_speed});
    val  = (den == '0) ? lo_s : qs + lo_s;
    if (val > hi_s) val = hi_s;
    if (val < lo_s) val = lo_s;
    target = val[SPD_W-1:0];

    elapsed = now - last_step_time;
    step    = elapsed >= TIME_W'(wait_ms);

    up_sum  = {1'b0, current_speed} + {1'b0, ramp_step};
    dn_diff = $signed({2'b00, current_speed}) - $signed({2'b00, ramp_step});

    speed_next = current_speed;
    if (current_speed < target) begin
      speed_next = (up_sum >= {1'b0, max_speed}) ? max_speed : up_sum[SPD_W-1:0];
    end else if (current_speed > target) begin
      speed_next = (dn_diff <= $signed({2'b00, min_speed})) ? min_speed
                                                             : dn_diff[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thr_off  <= $signed({1'b0, in_throttle}) - $signed({1'b0, thr_neutral});
      spd_span <= $signed({1'b0, max_speed}) - $signed({1'b0, min_speed});
      den      <= $signed({1'b0, full_throttle}) - $signed({1'b0, thr_neutral});
      now      <= in_time_ms;
    end
    if (cmd.mul) begin
      quo  <= prod_abs[QUO_W-1:0];
      rem  <= '0;
      dmag <= den_abs[THR_W-1:0];
      neg  <= prod[PROD_W-1] ^ den[DIFF_W-1];
    end
    if (cmd.div_step) begin
      quo <= {quo[QUO_W-2:0], sub_ok};
      rem <= sub_ok ? THR_W'(shifted - {1'b0, dmag}) : shifted[THR_W-1:0];
    end
    if (cmd.finish) begin
      out_speed        <= step ? speed_next : current_speed;
      out_target_speed <= target;
      out_stepped      <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_speed  <= '0;
      last_step_time <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (step) begin
          current_speed  <= speed_next;
          last_step_time <= now;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== sv/throttle_linear_ramp_top.sv =====
// a request runs through the product, 18 divide steps and finish from
//   request accept to result valid; finish waits until the output register is free
// one request at a time, paced by the 1-bit-per-cycle divider
// a result waits in the output register while the next request is accepted
// reset (rst, synchronous): config to defaults, speed and last step time to
//   zero, no result pending
// ----------------------------------------------------------------------------
// throttle_linear_ramp_top
// maps throttle linearly to a target speed and slews the held speed toward it
// ----------------------------------------------------------------------------
`default_nettype none

module throttle_linear_ramp_top (
  input  wire logic clk,
  input  wire logic rst,
  trl_in_if.sink    sample,
  trl_out_if.source result,
  trl_cfg_if.sink   cfg
);

  trl_pkg::trl_cmd_t cmd;
  trl_pkg::trl_sts_t sts;

  // config writes are taken on any cycle
  assign cfg.ready = 1'b1;

  // controller: request handshake and step sequencing
  trl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: mapping, serial divider, ramp state and output register
  trl_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .in_throttle      (sample.throttle),
    .in_time_ms       (sample.time_ms),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_speed        (result.speed),
    .out_target_speed (result.target_speed),
    .out_stepped      (result.stepped)
  );

endmodule

`default_nettype wire

// ===== sv/trl_checker.sv =====
// ----------------------------------------------------------------------------
// trl_checker
// port-level checks on request and result channels, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module trl_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [trl_pkg::SPD_W-1:0]   out_speed,
  input wire logic [trl_pkg::SPD_W-1:0]   out_target_speed,
  input wire logic                        out_stepped
);

  // held result does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_speed) &&
      $stable(out_target_speed) && $stable(out_stepped))
    else $error("result changed while stalled");

  // block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // a fresh result only appears while the request side is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in flight");

  // out of reset: ready for a request, nothing pending
  a_reset_state: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind throttle_linear_ramp_top trl_checker u_trl_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (sample.valid),
  .in_ready         (sample.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .out_speed        (result.speed),
  .out_target_speed (result.target_speed),
  .out_stepped      (result.stepped)
);

`default_nettype wire

// ===== tb/sv/ramp_speed_check.sv =====
// ----------------------------------------------------------------------------
// ramp_speed_check
// watches the request, result and register channels of the throttle ramp,
// predicts target speed, held speed and step flag per request, and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ramp_speed_check (
  input  logic        clk,
  input  logic        rst,
  trl_in_if           sample,
  trl_out_if          result,
  trl_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned step_count
);
  localparam int THR_W  = trl_pkg::THR_W;
  localparam int SPD_W  = trl_pkg::SPD_W;
  localparam int TIME_W = trl_pkg::TIME_W;
  localparam int WAIT_W = trl_pkg::WAIT_W;

  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic [SPD_W-1:0] target_speed;
    logic             stepped;
  } speed_result_t;

  // register copies
  logic [THR_W-1:0]  neutral_thr;
  logic [THR_W-1:0]  full_thr;
  logic [SPD_W-1:0]  min_spd;
  logic [SPD_W-1:0]  max_spd;
  logic [SPD_W-1:0]  ramp_amt;
  logic [WAIT_W-1:0] hold_ms;

  // ramp state
  logic [SPD_W-1:0]  held_speed;
  logic [TIME_W-1:0] last_step_ms;

  speed_result_t expected_speeds[$];

  // linear throttle map, quotient truncated toward zero, then clamped
  function automatic logic [SPD_W-1:0] mapped_target(logic [THR_W-1:0] thr);
    longint lo, hi, span, t, n, v;
    lo   = min_spd;
    hi   = max_spd;
    t    = thr;
    n    = neutral_thr;
    span = full_thr;
    span = span - n;
    if (span == 0) begin
      v = lo;
    end else begin
      v = ((t - n) * (hi - lo)) / span + lo;
    end
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[SPD_W-1:0];
  endfunction

  // one request: map, decide on a step, move the held speed
  function automatic speed_result_t advance_ramp(logic [THR_W-1:0] thr,
                                                 logic [TIME_W-1:0] now);
    speed_result_t    r;
    logic [TIME_W-1:0] elapsed;
    int               cur, amt;
    r.target_speed = mapped_target(thr);
    elapsed        = now - last_step_ms;
    r.stepped      = (elapsed >= {{(TIME_W-WAIT_W){1'b0}}, hold_ms});
    if (r.stepped) begin
      last_step_ms = now;
      step_count++;
      if (held_speed != r.target_speed) begin
        cur = held_speed;
        amt = ramp_amt;
        if (held_speed < r.target_speed) begin
          if (cur + amt >= int'(max_spd)) held_speed = max_spd;
          else held_speed = SPD_W'(cur + amt);
        end else begin
          if (cur - amt <= int'(min_spd)) held_speed = min_spd;
          else held_speed = SPD_W'(cur - amt);
        end
      end
    end
    r.speed = held_speed;
    return r;
  endfunction

  always @(posedge clk) begin
    speed_result_t want;
    if (rst) begin
      neutral_thr  = '0;
      full_thr     = 10'd1023;
      min_spd      = '0;
      max_spd      = 8'd255;
      ramp_amt     = 8'd1;
      hold_ms      = 16'd10;
      held_speed   = '0;
      last_step_ms = '0;
      expected_speeds.delete();
      mismatches   = 0;
      checked      = 0;
      step_count   = 0;
    end else begin
      // results first: a result always belongs to an earlier request
      if (result.valid && result.ready) begin
        if (expected_speeds.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting: speed %0d target %0d stepped %0b",
                   $time, result.speed, result.target_speed, result.stepped);
        end else begin
          want = expected_speeds.pop_front();
          checked++;
          if (result.speed !== want.speed) begin
            mismatches++;
            $display("%0t: speed expected %0d actual %0d", $time, want.speed, result.speed);
          end
          if (result.target_speed !== want.target_speed) begin
            mismatches++;
            $display("%0t: target_speed expected %0d actual %0d",
                     $time, want.target_speed, result.target_speed);
          end
          if (result.stepped !== want.stepped) begin
            mismatches++;
            $display("%0t: stepped expected %0b actual %0b", $time, want.stepped, result.stepped);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (trl_pkg::cfg_idx_t'(cfg.index))
          trl_pkg::CFG_THR_NEUTRAL:   neutral_thr = cfg.data[THR_W-1:0];
          trl_pkg::CFG_FULL_THROTTLE: full_thr    = cfg.data[THR_W-1:0];
          trl_pkg::CFG_MIN_SPEED:     min_spd     = cfg.data[SPD_W-1:0];
          trl_pkg::CFG_MAX_SPEED:     max_spd     = cfg.data[SPD_W-1:0];
          trl_pkg::CFG_RAMP_STEP:     ramp_amt    = cfg.data[SPD_W-1:0];
          trl_pkg::CFG_WAIT_MS:       hold_ms     = cfg.data[WAIT_W-1:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        expected_speeds.push_back(advance_ramp(sample.throttle, sample.time_ms));
    end
    pending = expected_speeds.size();
  end

endmodule

// ===== tb/sv/tb_throttle_linear_ramp_top.sv =====
// ----------------------------------------------------------------------------
// tb_throttle_linear_ramp_top
// drives throttle requests and register writes into the ramp block, with
// bursty requests and a stalling result side; ramp_speed_check does the
// prediction and comparison, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_throttle_linear_ramp_top;
  localparam int THR_W      = trl_pkg::THR_W;
  localparam int TIME_W     = trl_pkg::TIME_W;
  localparam int CFG_DATA_W = trl_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trl_in_if  sample_if ();
  trl_out_if result_if ();
  trl_cfg_if cfg_if ();

  int unsigned mismatches, pending, checked, step_count;

  throttle_linear_ramp_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  ramp_speed_check speed_check (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_if),
    .result     (result_if),
    .cfg        (cfg_if),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .step_count (step_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // result side: ready follows an open/closed window that repeats with a
  // random period, re-rolled after a random epoch; at least a third of the
  // windows are fully open so there are stretches with no stall at all
  // ---------------------------------------------------------------------------
  logic        rcv_ready  = 1'b0;
  int unsigned rcv_epoch  = 0;
  int unsigned rcv_period = 1;
  int unsigned rcv_open   = 1;
  int unsigned rcv_phase  = 0;

  assign result_if.ready = rcv_ready;

  always @(posedge clk) begin
    if (rcv_epoch == 0) begin
      rcv_epoch  <= $urandom_range(100, 400);
      rcv_period <= $urandom_range(2, 64);
      rcv_open   <= ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(1, 63);
      rcv_phase  <= 0;
    end else begin
      rcv_epoch <= rcv_epoch - 1;
      rcv_phase <= (rcv_phase + 1 >= rcv_period) ? 0 : rcv_phase + 1;
    end
    rcv_ready <= (rcv_phase < rcv_open);
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  int unsigned burst_left    = 0;
  bit          sender_gaps   = 1'b1;
  int unsigned settings_used = 0;

  // one request; at the start of each burst an optional gap drops valid,
  // otherwise valid stays high from one request into the next
  task automatic push_sample(input logic [THR_W-1:0] thr, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 45) : 0;
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_if.valid    <= 1'b1;
    sample_if.throttle <= thr;
    sample_if.time_ms  <= stamp;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic settle();
    sample_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
  endtask

  // a single register write; valid is left high for back-to-back writes
  task automatic write_reg(input trl_pkg::cfg_idx_t idx, input int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // full register set, only called while the block is idle
  task automatic program_regs(input int unsigned neutral, input int unsigned full,
                              input int unsigned lo_spd, input int unsigned hi_spd,
                              input int unsigned step_amt, input int unsigned hold);
    write_reg(trl_pkg::CFG_THR_NEUTRAL, neutral);
    write_reg(trl_pkg::CFG_FULL_THROTTLE, full);
    write_reg(trl_pkg::CFG_MIN_SPEED, lo_spd);
    write_reg(trl_pkg::CFG_MAX_SPEED, hi_spd);
    write_reg(trl_pkg::CFG_RAMP_STEP, step_amt);
    write_reg(trl_pkg::CFG_WAIT_MS, hold);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // register value: mostly a typical range, sometimes an extreme or anything
  function automatic int unsigned pick_reg(int unsigned typ_lo, int unsigned typ_hi,
                                           int unsigned full_max);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return full_max;
      2:       return $urandom_range(0, full_max);
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  // current register set of the random phase
  int unsigned r_neutral, r_full, r_min, r_max, r_step, r_hold;
  logic [THR_W-1:0]  thr;
  logic [TIME_W-1:0] stamp;

  initial begin
    sample_if.valid    <= 1'b0;
    sample_if.throttle <= '0;
    sample_if.time_ms  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= trl_pkg::CFG_THR_NEUTRAL;
    cfg_if.data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // -------------------------------------------------------------------------
    // directed part
    // -------------------------------------------------------------------------
    // reset defaults: no step at time zero, then a due step, a huge elapsed
    // time, and the millisecond counter wrapping past all ones
    push_sample(10'd0, 32'd0);
    push_sample(10'd1023, 32'd10);
    push_sample(10'd512, 32'hFFFF_FFFF);
    push_sample(10'd1023, 32'd5);
    push_sample(10'd1023, 32'd9);

    // zero wait with the largest step: saturate at the top, then the bottom
    settle();
    program_regs(0, 1023, 0, 255, 255, 0);
    push_sample(10'd1023, 32'd9);
    push_sample(10'd0, 32'd9);

    // overshoot: step of 100 around a mid-scale target bounces past it
    settle();
    program_regs(0, 1023, 0, 255, 100, 0);
    push_sample(10'd512, 32'd100);
    push_sample(10'd512, 32'd100);
    push_sample(10'd512, 32'd100);

    // min above max with a zero step: min wins the target, steps snap to max
    settle();
    program_regs(0, 1023, 150, 50, 0, 0);
    push_sample(10'd0, 32'd7);
    push_sample(10'd1023, 32'd7);

    // zero throttle span, plus an item just short of the wait
    settle();
    program_regs(300, 300, 10, 200, 5, 3);
    push_sample(10'd300, 32'd20);
    push_sample(10'd1023, 32'd22);
    push_sample(10'd0, 32'd23);

    // full throttle below neutral: negative divisor
    settle();
    program_regs(800, 200, 10, 200, 40, 1);
    push_sample(10'd100, 32'd30);
    push_sample(10'd500, 32'd31);
    push_sample(10'd900, 32'd32);

    // throttle below neutral, and the longest wait
    settle();
    program_regs(400, 1000, 20, 220, 255, 65535);
    push_sample(10'd0, 32'd40);
    push_sample(10'd1023, 32'd65575);

    // -------------------------------------------------------------------------
    // random part: ten register settings of sixty requests each; the first
    // two are the all-low and all-high extremes
    // -------------------------------------------------------------------------
    stamp = 32'd65575;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        {r_neutral, r_full, r_min, r_max, r_step, r_hold} = {32'd0, 32'd0, 32'd0,
                                                             32'd0, 32'd0, 32'd0};
      end else if (ph == 1) begin
        {r_neutral, r_full, r_min, r_max, r_step, r_hold} = {32'd1023, 32'd1023, 32'd255,
                                                             32'd255, 32'd255, 32'd65535};
      end else begin
        r_neutral = pick_reg(0, 300, 1023);
        r_full    = pick_reg(600, 1023, 1023);
        r_min     = pick_reg(0, 100, 255);
        r_max     = pick_reg(150, 255, 255);
        r_step    = pick_reg(1, 30, 255);
        r_hold    = pick_reg(0, 50, 65535);
      end
      settle();
      program_regs(r_neutral, r_full, r_min, r_max, r_step, r_hold);
      // every third setting runs with no sender gaps
      sender_gaps = (ph % 3 != 2);

      for (int i = 0; i < 60; i++) begin
        // time mostly moves forward around the wait, with the odd jump and wrap
        case ($urandom_range(0, 19))
          0:       stamp = $urandom();
          1:       stamp = 32'hFFFF_FFF0 + $urandom_range(0, 15);
          default: stamp = stamp + $urandom_range(0, 2 * r_hold + 1);
        endcase
        // throttle near the interesting points of the map, or anywhere
        case ($urandom_range(0, 9))
          0:       thr = '0;
          1:       thr = '1;
          2:       thr = THR_W'(r_neutral);
          3:       thr = THR_W'(r_full);
          4:       thr = THR_W'(r_neutral + 1);
          default: thr = THR_W'($urandom_range(0, 1023));
        endcase
        push_sample(thr, stamp);
      end
    end

    // drain, then allow a result's worth of latency for anything stray
    settle();
    repeat (40) @(posedge clk);

    $display("%0d requests checked over %0d register settings, %0d of them with a ramp step",
             checked, settings_used, step_count);
    $display("spans zero and inverted, speed range inverted, zero wait and step, overshoot, wrap");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5ms;
    $display("%0t: run limit reached with %0d results outstanding", $time, pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
